// ===== rtl/core/ghed_pkg.sv =====
// ----------------------------------------------------------------------------
// ghed_pkg : shared types and constants for the gamepad hold/edge/deadzone block
// Slot masks, register indexes, reset values and the divider request/response.
// ----------------------------------------------------------------------------
package ghed_pkg;

    localparam int PAD_COUNT_DEF = 4;
    localparam int BUTTON_SLOTS  = 14;
    localparam int COMBO_SLOTS   = 4;
    localparam int SLOT_COUNT    = BUTTON_SLOTS + COMBO_SLOTS;
    localparam int AXIS_UNITS    = 80;
    localparam int COUNT_W       = 16;

    localparam logic [4:0] LAST_SLOT = 5'(SLOT_COUNT - 1);

    localparam logic [6:0] DEAD_ZONE_RST = 7'd7;
    localparam logic [6:0] FULL_X_RST    = 7'd59;
    localparam logic [6:0] FULL_Y_RST    = 7'd61;

    localparam logic [1:0] CFG_DEAD_ZONE = 2'd0;
    localparam logic [1:0] CFG_FULL_X    = 2'd1;
    localparam logic [1:0] CFG_FULL_Y    = 2'd2;

    localparam logic [15:0] MASK_L = 16'h0020;
    localparam logic [15:0] MASK_R = 16'h0010;

    typedef struct packed {
        logic       start;
        logic [7:0] mag;
        logic [6:0] lo;
        logic [6:0] hi;
    } ghed_div_req_t;

    typedef struct packed {
        logic       done;
        logic [6:0] quo;
    } ghed_div_rsp_t;

    // button word mask watched by each slot; combo slots list the third button
    function automatic logic [15:0] slot_mask(input logic [4:0] slot_idx);
        logic [15:0] m;
        unique case (slot_idx)
            5'd0:    m = 16'h8000;
            5'd1:    m = 16'h4000;
            5'd2:    m = 16'h0002;
            5'd3:    m = 16'h0004;
            5'd4:    m = 16'h0008;
            5'd5:    m = 16'h0001;
            5'd6:    m = 16'h2000;
            5'd7:    m = 16'h0020;
            5'd8:    m = 16'h0010;
            5'd9:    m = 16'h0800;
            5'd10:   m = 16'h0400;
            5'd11:   m = 16'h0200;
            5'd12:   m = 16'h0100;
            5'd13:   m = 16'h1000;
            5'd14:   m = 16'h0004;
            5'd15:   m = 16'h2000;
            5'd16:   m = 16'h8000;
            5'd17:   m = 16'h4000;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/ghed_ram.sv =====
// ----------------------------------------------------------------------------
// ghed_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ghed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 72,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ghed_axis_div.sv =====
// ----------------------------------------------------------------------------
// ghed_axis_div : stick axis normaliser
// Clamps a magnitude to the dead zone / full scale window and, unless the span
// is zero or inverted, divides the scaled offset by the span, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ghed_axis_div
    import ghed_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ghed_div_req_t req,
    output ghed_div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  cnt_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  sh_reg;
    logic [6:0]  den_reg;

    logic        span_zero;
    logic        inverted;
    logic        over;
    logic        under;
    logic [6:0]  clamped;
    logic [6:0]  diff;
    logic [13:0] num;
    logic [8:0]  trial;
    logic        qbit;
    logic [6:0]  rem_next;
    logic [6:0]  sh_next;

    always_comb
    begin
        span_zero = (req.hi == req.lo);
        inverted  = (req.hi < req.lo);
        over      = (req.mag > {1'b0, req.hi});
        under     = (req.mag < {1'b0, req.lo});
        clamped   = over ? req.hi : (under ? req.lo : req.mag[6:0]);
        diff      = clamped - req.lo;
        num       = 14'(32'(diff) * AXIS_UNITS);
        trial     = {1'b0, rem_reg, sh_reg[6]} - {2'b00, den_reg};
        qbit      = ~trial[8];
        rem_next  = qbit ? trial[6:0] : {rem_reg[5:0], sh_reg[6]};
        sh_next   = {sh_reg[5:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= ~(span_zero | inverted);
                done_reg <= span_zero | inverted;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd6)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.hi - req.lo;
            rem_reg <= num[13:7];
            if (span_zero)
            begin
                sh_reg <= '0;
            end
            else if (inverted)
            begin
                sh_reg <= over ? 7'(AXIS_UNITS) : 7'd0;
            end
            else
            begin
                sh_reg <= num[6:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sh_reg;

endmodule

// ===== rtl/core/gamepad_hold_edge_deadzone.sv =====
// ----------------------------------------------------------------------------
// gamepad_hold_edge_deadzone : per-pad hold counters, edges and stick deadzone
// Each poll updates one pad and produces eighteen results, one per slot.
//
//   Channel | Dir | Handshake            | Payload
//   in      | in  | in_valid / in_stall  | pad_index, button_bits, raw_stick_x/y,
//           |     |                      | elapsed_ticks
//   out     | out | out_valid / out_stall| pad_number, slot, held_frames, edges,
//           |     |                      | held_buttons, axis_x/y, idle_ticks, flags
//   cfg     | in  | cfg_write            | cfg_index, cfg_data
//
// A poll takes two passes of the 7-step shared divider (skipped with L+R
// held), then a read and a write state per slot on the counter RAM; the
// write state waits while a stalled result still holds the output register.
// in_stall is high from the transfer of a poll until its last result is
// loaded into the output register. Reset is asynchronous; counter RAM rows
// read as zero until a pad's first poll has written them.
// ----------------------------------------------------------------------------
module gamepad_hold_edge_deadzone
    import ghed_pkg::*;
#(
    parameter int PAD_COUNT = PAD_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         pad_index,
    input  logic [15:0]        button_bits,
    input  logic signed [7:0]  raw_stick_x,
    input  logic signed [7:0]  raw_stick_y,
    input  logic [7:0]         elapsed_ticks,

    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         pad_number,
    output logic [4:0]         slot,
    output logic [15:0]        held_frames,
    output logic [15:0]        pressed_edges,
    output logic [15:0]        released_edges,
    output logic [15:0]        held_buttons,
    output logic signed [7:0]  axis_x,
    output logic signed [7:0]  axis_y,
    output logic [31:0]        idle_ticks,
    output logic               combo_mode,
    output logic               last_of_run
);

    localparam int PAD_AW    = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int RAM_DEPTH = PAD_COUNT * SLOT_COUNT;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DX,
        S_WX,
        S_DY,
        S_WY,
        S_UPD,
        S_RD,
        S_WR
    } state_t;

    state_t state_reg;

    logic [6:0]  dz_reg;
    logic [6:0]  fsx_reg;
    logic [6:0]  fsy_reg;

    logic [1:0]  pad_in_reg;
    logic [15:0] btn_reg;
    logic [7:0]  raw_x_reg;
    logic [7:0]  raw_y_reg;
    logic [7:0]  dt_reg;
    logic        combo_reg;
    logic [4:0]  slot_reg;
    logic [6:0]  qx_reg;
    logic [6:0]  qy_reg;

    logic [15:0] prior_btn_reg [PAD_COUNT];
    logic [7:0]  prior_ax_reg  [PAD_COUNT];
    logic [7:0]  prior_ay_reg  [PAD_COUNT];
    logic [31:0] idle_reg      [PAD_COUNT];
    logic [PAD_COUNT-1:0] pad_valid_reg;

    logic [15:0] item_pressed_reg;
    logic [15:0] item_released_reg;
    logic [15:0] item_held_reg;
    logic [7:0]  item_ax_reg;
    logic [7:0]  item_ay_reg;
    logic [31:0] item_idle_reg;

    logic        out_valid_reg;
    logic [1:0]  out_pad_reg;
    logic [4:0]  out_slot_reg;
    logic [15:0] out_frames_reg;
    logic [15:0] out_pressed_reg;
    logic [15:0] out_released_reg;
    logic [15:0] out_held_reg;
    logic [7:0]  out_ax_reg;
    logic [7:0]  out_ay_reg;
    logic [31:0] out_idle_reg;
    logic        out_combo_reg;
    logic        out_last_reg;

    logic [PAD_AW-1:0] pad_sel;
    logic              pad_ok;
    logic              combo_in;
    logic [7:0]        mag_x;
    logic [7:0]        mag_y;
    logic [7:0]        ax_w;
    logic [7:0]        ay_w;
    logic [15:0]       prev_btn;
    logic [15:0]       pressed_w;
    logic [15:0]       released_w;
    logic [32:0]       idle_sum;
    logic [31:0]       idle_sat;
    logic              idle_clear;
    logic              slot_hit;
    logic [15:0]       cnt_old;
    logic [15:0]       cnt_new;
    logic              load;
    logic [RAM_AW-1:0] ram_addr;
    logic [15:0]       ram_rd;

    ghed_div_req_t div_req;
    ghed_div_rsp_t div_rsp;

    always_comb
    begin
        pad_sel    = PAD_AW'(pad_in_reg);
        pad_ok     = ({30'd0, pad_index} < 32'(PAD_COUNT));
        combo_in   = ((button_bits & MASK_L) != '0) && ((button_bits & MASK_R) != '0);
        mag_x      = raw_x_reg[7] ? (8'd0 - raw_x_reg) : raw_x_reg;
        mag_y      = raw_y_reg[7] ? (8'd0 - raw_y_reg) : raw_y_reg;
        ax_w       = raw_x_reg[7] ? (8'd0 - {1'b0, qx_reg}) : {1'b0, qx_reg};
        ay_w       = raw_y_reg[7] ? (8'd0 - {1'b0, qy_reg}) : {1'b0, qy_reg};
        prev_btn   = prior_btn_reg[pad_sel];
        pressed_w  = ~prev_btn & btn_reg;
        released_w = prev_btn & ~btn_reg;
        idle_clear = (pressed_w != '0) || (ax_w != prior_ax_reg[pad_sel])
                     || (ay_w != prior_ay_reg[pad_sel]);
        idle_sum   = {1'b0, idle_reg[pad_sel]} + {25'd0, dt_reg};
        idle_sat   = idle_sum[32] ? '1 : idle_sum[31:0];

        slot_hit   = ((slot_reg >= 5'(BUTTON_SLOTS)) == combo_reg)
                     && ((btn_reg & slot_mask(slot_reg)) != '0);
        cnt_old    = pad_valid_reg[pad_sel] ? ram_rd : 16'd0;
        cnt_new    = !slot_hit ? 16'd0 : ((cnt_old == '1) ? cnt_old : cnt_old + 16'd1);
        load       = (state_reg == S_WR) && (!out_valid_reg || !out_stall);
        ram_addr   = RAM_AW'(32'(pad_sel) * SLOT_COUNT + 32'(slot_reg));

        div_req.start = (state_reg == S_DX) || (state_reg == S_DY);
        div_req.mag   = (state_reg == S_DY) ? mag_y : mag_x;
        div_req.lo    = dz_reg;
        div_req.hi    = (state_reg == S_DY) ? fsy_reg : fsx_reg;
    end

    ghed_axis_div u_axis_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ghed_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (RAM_DEPTH)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (load),
        .wr_addr (ram_addr),
        .wr_data (cnt_new),
        .rd_addr (ram_addr),
        .rd_data (ram_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            dz_reg            <= DEAD_ZONE_RST;
            fsx_reg           <= FULL_X_RST;
            fsy_reg           <= FULL_Y_RST;
            pad_in_reg        <= '0;
            btn_reg           <= '0;
            raw_x_reg         <= '0;
            raw_y_reg         <= '0;
            dt_reg            <= '0;
            combo_reg         <= 1'b0;
            slot_reg          <= '0;
            qx_reg            <= '0;
            qy_reg            <= '0;
            pad_valid_reg     <= '0;
            item_pressed_reg  <= '0;
            item_released_reg <= '0;
            item_held_reg     <= '0;
            item_ax_reg       <= '0;
            item_ay_reg       <= '0;
            item_idle_reg     <= '0;
            out_valid_reg     <= 1'b0;
            out_pad_reg       <= '0;
            out_slot_reg      <= '0;
            out_frames_reg    <= '0;
            out_pressed_reg   <= '0;
            out_released_reg  <= '0;
            out_held_reg      <= '0;
            out_ax_reg        <= '0;
            out_ay_reg        <= '0;
            out_idle_reg      <= '0;
            out_combo_reg     <= 1'b0;
            out_last_reg      <= 1'b0;
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                prior_btn_reg[i] <= '0;
                prior_ax_reg[i]  <= '0;
                prior_ay_reg[i]  <= '0;
                idle_reg[i]      <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_DEAD_ZONE: dz_reg  <= cfg_data;
                    CFG_FULL_X:    fsx_reg <= cfg_data;
                    CFG_FULL_Y:    fsy_reg <= cfg_data;
                    default:       ;
                endcase
            end

            if (out_valid_reg && !out_stall && !load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && pad_ok)
                    begin
                        pad_in_reg <= pad_index;
                        btn_reg    <= button_bits;
                        raw_x_reg  <= raw_stick_x;
                        raw_y_reg  <= raw_stick_y;
                        dt_reg     <= elapsed_ticks;
                        combo_reg  <= combo_in;
                        slot_reg   <= '0;
                        state_reg  <= combo_in ? S_UPD : S_DX;
                    end
                end
                S_DX:
                begin
                    state_reg <= S_WX;
                end
                S_WX:
                begin
                    if (div_rsp.done)
                    begin
                        qx_reg    <= div_rsp.quo;
                        state_reg <= S_DY;
                    end
                end
                S_DY:
                begin
                    state_reg <= S_WY;
                end
                S_WY:
                begin
                    if (div_rsp.done)
                    begin
                        qy_reg    <= div_rsp.quo;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (combo_reg)
                    begin
                        prior_btn_reg[pad_sel] <= '0;
                        prior_ax_reg[pad_sel]  <= '0;
                        prior_ay_reg[pad_sel]  <= '0;
                        item_pressed_reg       <= '0;
                        item_released_reg      <= '0;
                        item_held_reg          <= '0;
                        item_ax_reg            <= '0;
                        item_ay_reg            <= '0;
                        item_idle_reg          <= idle_reg[pad_sel];
                    end
                    else
                    begin
                        prior_btn_reg[pad_sel] <= btn_reg;
                        prior_ax_reg[pad_sel]  <= ax_w;
                        prior_ay_reg[pad_sel]  <= ay_w;
                        idle_reg[pad_sel]      <= idle_clear ? 32'd0 : idle_sat;
                        item_pressed_reg       <= pressed_w;
                        item_released_reg      <= released_w;
                        item_held_reg          <= btn_reg;
                        item_ax_reg            <= ax_w;
                        item_ay_reg            <= ay_w;
                        item_idle_reg          <= idle_clear ? 32'd0 : idle_sat;
                    end
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    if (load)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_pad_reg      <= pad_in_reg;
                        out_slot_reg     <= slot_reg;
                        out_frames_reg   <= cnt_new;
                        out_pressed_reg  <= item_pressed_reg;
                        out_released_reg <= item_released_reg;
                        out_held_reg     <= item_held_reg;
                        out_ax_reg       <= item_ax_reg;
                        out_ay_reg       <= item_ay_reg;
                        out_idle_reg     <= item_idle_reg;
                        out_combo_reg    <= combo_reg;
                        out_last_reg     <= (slot_reg == LAST_SLOT);
                        if (slot_reg == LAST_SLOT)
                        begin
                            pad_valid_reg[pad_sel] <= 1'b1;
                            state_reg              <= S_IDLE;
                        end
                        else
                        begin
                            slot_reg  <= slot_reg + 5'd1;
                            state_reg <= S_RD;
                        end
                    end
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign pad_number     = out_pad_reg;
    assign slot           = out_slot_reg;
    assign held_frames    = out_frames_reg;
    assign pressed_edges  = out_pressed_reg;
    assign released_edges = out_released_reg;
    assign held_buttons   = out_held_reg;
    assign axis_x         = out_ax_reg;
    assign axis_y         = out_ay_reg;
    assign idle_ticks     = out_idle_reg;
    assign combo_mode     = out_combo_reg;
    assign last_of_run    = out_last_reg;

endmodule

// ===== rtl/core/ghed_checker.sv =====
// ----------------------------------------------------------------------------
// ghed_checker : port-level checks for the gamepad hold/edge/deadzone block
// Watches the result channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module ghed_checker
    import ghed_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [4:0]        slot,
    input logic [15:0]       held_frames,
    input logic [15:0]       pressed_edges,
    input logic [15:0]       released_edges,
    input logic [15:0]       held_buttons,
    input logic signed [7:0] axis_x,
    input logic signed [7:0] axis_y,
    input logic [31:0]       idle_ticks,
    input logic              combo_mode,
    input logic              last_of_run
);

    localparam logic signed [7:0] AXIS_MAX = 8'(AXIS_UNITS);
    localparam logic signed [7:0] AXIS_MIN = -8'(AXIS_UNITS);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot)
            && $stable(held_frames) && $stable(idle_ticks))
        else $error("result changed while stalled");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_run == (slot == LAST_SLOT)))
        else $error("last_of_run does not match final slot");

    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (slot != LAST_SLOT)
            |=> !out_valid || (slot == $past(slot) + 5'd1))
        else $error("result slots out of order");

    a_combo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && combo_mode |-> (pressed_edges == '0) && (released_edges == '0)
            && (held_buttons == '0) && (axis_x == '0) && (axis_y == '0))
        else $error("L+R result carries button or stick data");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_x <= AXIS_MAX) && (axis_x >= AXIS_MIN)
            && (axis_y <= AXIS_MAX) && (axis_y >= AXIS_MIN))
        else $error("normalised axis out of range");

endmodule

bind gamepad_hold_edge_deadzone ghed_checker u_ghed_checker (.*);
